// ===== hdl/rrrc_pkg.sv =====
// shared types and constants for the enumerative block codec
// payload structs, the per-cell stage record and the binomial helper; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrrc_pkg;

  // fixed field widths
  localparam int unsigned BLOCK_W   = 16;
  localparam int unsigned CLASS_W   = 5;
  localparam int unsigned OFFSET_W  = 14;
  localparam int unsigned DEF_BLOCK_BITS = 16;
  localparam int unsigned CLASS_NUM = 1 << CLASS_W;

  // command codes
  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // input transfer
  typedef struct packed {
    logic                cmd;
    logic [CLASS_W-1:0]  class_count;
    logic [BLOCK_W-1:0]  block;
    logic [OFFSET_W-1:0] offset;
  } in_t;

  // result transfer
  typedef struct packed {
    logic [BLOCK_W-1:0]  block_out;
    logic [OFFSET_W-1:0] offset_out;
    logic                error;
  } out_t;

  // record handed from cell to cell
  typedef struct packed {
    logic                cmd;
    logic [CLASS_W-1:0]  ones_left;  // set bits still to place or see
    logic [OFFSET_W-1:0] acc;        // running offset on encode, remainder on decode
    logic [BLOCK_W-1:0]  bits;       // source block on encode, built block on decode
    logic                err;
  } stage_t;

  // binomial coefficient by pascal rows, elaboration-time use only
  function automatic logic [31:0] binom(input int unsigned n, input int unsigned k);
    logic [31:0] row [0:32];
    int          i;
    int          m;
    for (m = 0; m <= 32; m++) begin
      row[m] = 32'd0;
    end
    row[0] = 32'd1;
    for (i = 1; i <= 32; i++) begin
      if (i <= int'(n)) begin
        for (m = 32; m >= 1; m--) begin
          if (m <= i) begin
            row[m] = row[m] + row[m-1];
          end
        end
      end
    end
    return (k <= 32) ? row[k] : 32'd0;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rrrc_cell.sv =====
// one bit position of the codec chain: encodes or decodes bit POS
// depends on rrrc_pkg for the stage record and binomial constants
`timescale 1ns / 1ps
`default_nettype none

module rrrc_cell #(
  parameter int unsigned POS = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             up_valid,
  output logic                  up_ready,
  input  wire rrrc_pkg::stage_t up_data,
  output logic                  dn_valid,
  input  wire logic             dn_ready,
  output rrrc_pkg::stage_t      dn_data
);

  logic [rrrc_pkg::OFFSET_W-1:0] coef_tbl [rrrc_pkg::CLASS_NUM];
  logic [rrrc_pkg::OFFSET_W-1:0] coef;
  logic                          ones_nz;
  logic                          valid_r;
  rrrc_pkg::stage_t              data_r;
  rrrc_pkg::stage_t              data_nxt;

  // C(POS, j) for every count j
  for (genvar k = 0; k < int'(rrrc_pkg::CLASS_NUM); k++) begin : g_coef
    assign coef_tbl[k] = rrrc_pkg::OFFSET_W'(rrrc_pkg::binom(POS, k));
  end

  assign coef    = coef_tbl[up_data.ones_left];
  assign ones_nz = (up_data.ones_left != '0);

  // bit step: add on encode, compare and subtract on decode
  always_comb begin
    data_nxt = up_data;
    unique case (up_data.cmd)
      rrrc_pkg::CMD_ENCODE: begin
        if (up_data.bits[POS]) begin
          if (!ones_nz) begin
            data_nxt.err = 1'b1;
          end else begin
            data_nxt.acc       = up_data.acc + coef;
            data_nxt.ones_left = up_data.ones_left - 1'b1;
          end
        end
      end
      rrrc_pkg::CMD_DECODE: begin
        if (ones_nz && (coef <= up_data.acc)) begin
          data_nxt.bits[POS] = 1'b1;
          data_nxt.acc       = up_data.acc - coef;
          data_nxt.ones_left = up_data.ones_left - 1'b1;
        end
      end
      default: begin
        data_nxt = up_data;
      end
    endcase
  end

  // stage register, moves whenever the next cell has room
  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== hdl/rrr_block_enumerative_codec.sv =====
// top level of the enumerative block codec: entry stage, cell chain, result formatting
// depends on rrrc_pkg and rrrc_cell
//
// usage:
//   in_valid/in_stall/in_data carry one request per transfer: cmd selects encode
//   (class_count, block -> offset_out) or decode (class_count, offset -> block_out).
//   out_valid/out_stall/out_data return exactly one result per request, in order.
//   a class that does not match the block popcount, block bits above BLOCK_BITS,
//   or an offset at or beyond C(BLOCK_BITS, class) give error with zero payload.
// pipeline: one entry check register plus one register per bit cell, the cells
//   scanning from the top bit down.
// throughput: one request per cycle while out_stall is low; every cell is a stage of its own.
// stall: a stalled result holds out_data; each stage moves when the one after it
//   is empty or moving, so bubbles close up and in_stall rises only once the
//   whole chain is full.
// reset: synchronous rst_n empties every stage; no other state is kept.
`timescale 1ns / 1ps
`default_nettype none

module rrr_block_enumerative_codec #(
  parameter int unsigned BLOCK_BITS = rrrc_pkg::DEF_BLOCK_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rrrc_pkg::in_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rrrc_pkg::out_t     out_data
);

  logic [rrrc_pkg::OFFSET_W:0] limit_tbl [rrrc_pkg::CLASS_NUM];
  logic                        chain_valid [BLOCK_BITS+1];
  logic                        chain_ready [BLOCK_BITS+1];
  rrrc_pkg::stage_t            chain_data  [BLOCK_BITS+1];
  logic                        entry_valid_r;
  rrrc_pkg::stage_t            entry_r;
  rrrc_pkg::stage_t            entry_nxt;
  logic                        wide_err;
  logic                        range_err;
  rrrc_pkg::stage_t            last;

  // C(BLOCK_BITS, class) bound for decode
  for (genvar k = 0; k < int'(rrrc_pkg::CLASS_NUM); k++) begin : g_limit
    assign limit_tbl[k] = (rrrc_pkg::OFFSET_W+1)'(rrrc_pkg::binom(BLOCK_BITS, k));
  end

  // entry checks
  assign wide_err  = |(rrrc_pkg::BLOCK_W'(in_data.block >> BLOCK_BITS));
  assign range_err = ({1'b0, in_data.offset} >= limit_tbl[in_data.class_count]);

  always_comb begin
    entry_nxt.cmd       = in_data.cmd;
    entry_nxt.ones_left = in_data.class_count;
    unique case (in_data.cmd)
      rrrc_pkg::CMD_ENCODE: begin
        entry_nxt.acc  = '0;
        entry_nxt.bits = in_data.block;
        entry_nxt.err  = wide_err;
      end
      rrrc_pkg::CMD_DECODE: begin
        entry_nxt.acc  = in_data.offset;
        entry_nxt.bits = '0;
        entry_nxt.err  = range_err;
      end
      default: begin
        entry_nxt.acc  = '0;
        entry_nxt.bits = '0;
        entry_nxt.err  = 1'b1;
      end
    endcase
  end

  // entry register
  assign in_stall = entry_valid_r && !chain_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else if (!in_stall) begin
      entry_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      entry_r <= entry_nxt;
    end
  end

  assign chain_valid[0] = entry_valid_r;
  assign chain_data[0]  = entry_r;

  // bit cells, highest position first
  for (genvar i = 0; i < int'(BLOCK_BITS); i++) begin : g_cell
    rrrc_cell #(
      .POS (BLOCK_BITS - 1 - i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (chain_valid[i]),
      .up_ready (chain_ready[i]),
      .up_data  (chain_data[i]),
      .dn_valid (chain_valid[i+1]),
      .dn_ready (chain_ready[i+1]),
      .dn_data  (chain_data[i+1])
    );
  end

  // result formatting from the last cell
  assign chain_ready[BLOCK_BITS] = !out_stall;
  assign last      = chain_data[BLOCK_BITS];
  assign out_valid = chain_valid[BLOCK_BITS];

  always_comb begin
    out_data.error      = last.err || (last.ones_left != '0);
    out_data.block_out  = '0;
    out_data.offset_out = '0;
    if (!out_data.error) begin
      if (last.cmd == rrrc_pkg::CMD_DECODE) begin
        out_data.block_out = last.bits;
      end else begin
        out_data.offset_out = last.acc;
      end
    end
  end

endmodule

`default_nettype wire
